// File: src/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants shared by the one-wire bus master unit.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int unsigned TICK_W = 10;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } owm_op_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_SLOT  = 4'd5,
        PH_WR_GAP   = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_GAP   = 4'd9
    } owm_phase_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_LOW     = 3'd3,
        REG_WRITE_SLOT    = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_GAP      = 3'd7
    } owm_reg_idx_t;

    localparam logic [TICK_W-1:0] RESET_LOW_DEF     = 10'd500;
    localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEF = 10'd30;
    localparam logic [TICK_W-1:0] RESET_TAIL_DEF    = 10'd470;
    localparam logic [TICK_W-1:0] WRITE_LOW_DEF     = 10'd5;
    localparam logic [TICK_W-1:0] WRITE_SLOT_DEF    = 10'd80;
    localparam logic [TICK_W-1:0] READ_LOW_DEF      = 10'd2;
    localparam logic [TICK_W-1:0] READ_SAMPLE_DEF   = 10'd14;
    localparam logic [TICK_W-1:0] READ_GAP_DEF      = 10'd15;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       line_level;
    } owm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       device_present;
        logic [7:0] received_byte;
    } owm_out_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] reset_tail_ticks;
        logic [TICK_W-1:0] write_low_ticks;
        logic [TICK_W-1:0] write_slot_ticks;
        logic [TICK_W-1:0] read_low_ticks;
        logic [TICK_W-1:0] read_sample_ticks;
        logic [TICK_W-1:0] read_gap_ticks;
    } owm_cfg_t;

endpackage

// File: src/owm_cfg.sv
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file behind an APB-style port; one 32-bit slot per register.
// ----------------------------------------------------------------------------
module owm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [owm_pkg::ADDR_W-1:0]     paddr,
    input  logic [owm_pkg::DATA_W-1:0]     pwdata,
    output logic [owm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output owm_pkg::owm_cfg_t              cfg
);
    import owm_pkg::*;

    owm_cfg_t          cfg_reg;
    owm_cfg_t          cfg_next;
    logic [2:0]        reg_idx;
    logic [TICK_W-1:0] wr_val;
    logic [TICK_W-1:0] rd_val;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_val  = pwdata[TICK_W-1:0];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RESET_LOW:     cfg_next.reset_low_ticks     = wr_val;
                REG_PRESENCE_WAIT: cfg_next.presence_wait_ticks = wr_val;
                REG_RESET_TAIL:    cfg_next.reset_tail_ticks    = wr_val;
                REG_WRITE_LOW:     cfg_next.write_low_ticks     = wr_val;
                REG_WRITE_SLOT:    cfg_next.write_slot_ticks    = wr_val;
                REG_READ_LOW:      cfg_next.read_low_ticks      = wr_val;
                REG_READ_SAMPLE:   cfg_next.read_sample_ticks   = wr_val;
                REG_READ_GAP:      cfg_next.read_gap_ticks      = wr_val;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= RESET_LOW_DEF;
            cfg_reg.presence_wait_ticks <= PRESENCE_WAIT_DEF;
            cfg_reg.reset_tail_ticks    <= RESET_TAIL_DEF;
            cfg_reg.write_low_ticks     <= WRITE_LOW_DEF;
            cfg_reg.write_slot_ticks    <= WRITE_SLOT_DEF;
            cfg_reg.read_low_ticks      <= READ_LOW_DEF;
            cfg_reg.read_sample_ticks   <= READ_SAMPLE_DEF;
            cfg_reg.read_gap_ticks      <= READ_GAP_DEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RESET_LOW:     rd_val = cfg_reg.reset_low_ticks;
            REG_PRESENCE_WAIT: rd_val = cfg_reg.presence_wait_ticks;
            REG_RESET_TAIL:    rd_val = cfg_reg.reset_tail_ticks;
            REG_WRITE_LOW:     rd_val = cfg_reg.write_low_ticks;
            REG_WRITE_SLOT:    rd_val = cfg_reg.write_slot_ticks;
            REG_READ_LOW:      rd_val = cfg_reg.read_low_ticks;
            REG_READ_SAMPLE:   rd_val = cfg_reg.read_sample_ticks;
            REG_READ_GAP:      rd_val = cfg_reg.read_gap_ticks;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = {{(DATA_W-TICK_W){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

// File: src/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: advances the reset / write byte / read byte phases one tick
// per accepted word and forms that tick's result.
// ----------------------------------------------------------------------------
module owm_core #(
    parameter int unsigned BYTE_GAP_TICKS = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  owm_pkg::owm_in_t   in_word,
    input  owm_pkg::owm_cfg_t  cfg,
    output owm_pkg::owm_out_t  result
);
    import owm_pkg::*;

    localparam logic [TICK_W-1:0] GAP_LEN = TICK_W'(BYTE_GAP_TICKS);

    owm_phase_t        phase_reg,    phase_next;
    logic [TICK_W-1:0] tick_reg,     tick_next;
    logic [2:0]        bit_reg,      bit_next;
    logic [7:0]        shift_reg,    shift_next;
    logic              presence_reg, presence_next;
    logic [7:0]        hold_reg,     hold_next;

    // state after a possible command start
    owm_phase_t        ph_start;
    logic [TICK_W-1:0] tick_start;
    logic [2:0]        bit_start;
    logic [7:0]        shift_start;

    logic [TICK_W-1:0] phase_len;
    logic [TICK_W-1:0] tick_inc;
    logic              phase_end;

    // command start
    always_comb
    begin
        ph_start    = phase_reg;
        tick_start  = tick_reg;
        bit_start   = bit_reg;
        shift_start = shift_reg;
        if (phase_reg == PH_IDLE)
        begin
            tick_start = '0;
            bit_start  = '0;
            case (in_word.operation)
                OP_RESET: ph_start = PH_RST_LOW;
                OP_WRITE:
                begin
                    ph_start    = PH_WR_LOW;
                    shift_start = in_word.data_byte;
                end
                OP_READ:
                begin
                    ph_start    = PH_RD_LOW;
                    shift_start = '0;
                end
                default: ph_start = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (ph_start)
            PH_RST_LOW:  phase_len = cfg.reset_low_ticks;
            PH_RST_WAIT: phase_len = cfg.presence_wait_ticks;
            PH_RST_TAIL: phase_len = cfg.reset_tail_ticks;
            PH_WR_LOW:   phase_len = cfg.write_low_ticks;
            PH_WR_SLOT:  phase_len = cfg.write_slot_ticks;
            PH_WR_GAP:   phase_len = GAP_LEN;
            PH_RD_LOW:   phase_len = cfg.read_low_ticks;
            PH_RD_WAIT:  phase_len = cfg.read_sample_ticks;
            PH_RD_GAP:   phase_len = cfg.read_gap_ticks;
            default:     phase_len = TICK_W'(1);
        endcase
    end

    // a zero length compares as ended on the first tick
    assign tick_inc  = tick_start + TICK_W'(1);
    assign phase_end = (ph_start != PH_IDLE) && (tick_inc >= phase_len);

    // next state
    always_comb
    begin
        phase_next    = ph_start;
        tick_next     = tick_start;
        bit_next      = bit_start;
        shift_next    = shift_start;
        presence_next = presence_reg;
        hold_next     = hold_reg;
        if (ph_start != PH_IDLE)
        begin
            tick_next = phase_end ? '0 : tick_inc;
            if (phase_end)
            begin
                case (ph_start)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = !in_word.line_level;
                        phase_next    = PH_RST_TAIL;
                    end
                    PH_WR_LOW:   phase_next = PH_WR_SLOT;
                    PH_WR_SLOT:
                    begin
                        if (bit_start == 3'd7)
                        begin
                            bit_next   = '0;
                            phase_next = (BYTE_GAP_TICKS > 0) ? PH_WR_GAP : PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_start + 3'd1;
                            phase_next = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:   phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (in_word.line_level)
                        begin
                            shift_next[bit_start] = 1'b1;
                        end
                        phase_next = PH_RD_GAP;
                    end
                    PH_RD_GAP:
                    begin
                        if (bit_start == 3'd7)
                        begin
                            bit_next   = '0;
                            hold_next  = shift_start;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_start + 3'd1;
                            phase_next = PH_RD_LOW;
                        end
                    end
                    default:     phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        case (ph_start)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: result.drive_low = 1'b1;
            PH_WR_SLOT:                       result.drive_low = !shift_start[bit_start];
            default:                          result.drive_low = 1'b0;
        endcase
        result.busy_res       = (phase_next != PH_IDLE);
        result.done_res       = (ph_start != PH_IDLE) && (phase_next == PH_IDLE);
        result.device_present = presence_next;
        result.received_byte  = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            hold_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            hold_reg     <= hold_next;
        end
    end

    a_idle_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bit_reg == 3'd0)
        else $error("bit index not cleared while idle");

    a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg != {TICK_W{1'b1}})
        else $error("tick counter reached its top value");

    a_presence_only_at_sample: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg != PH_RST_WAIT |=> presence_reg == $past(presence_reg))
        else $error("presence changed outside the presence sample phase");

endmodule

// File: src/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// One-wire bus master stepped once per accepted tick word: reset with
// presence detect, byte write and byte read, timing from APB registers.
// ----------------------------------------------------------------------------
// The result word of a tick is registered. Throughput: one tick word per
// cycle while in_stall is low; the sequencer state updates in a single pass
// between the state registers and the output register.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset: sequencer idle, counters, presence and read byte cleared, timing
// registers at their default values, output buffer empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit #(
    parameter int unsigned BYTE_GAP_TICKS = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  owm_pkg::owm_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output owm_pkg::owm_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [owm_pkg::ADDR_W-1:0]     paddr,
    input  logic [owm_pkg::DATA_W-1:0]     pwdata,
    output logic [owm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import owm_pkg::*;

    owm_cfg_t cfg;
    owm_out_t step_res;
    logic     in_acc;
    logic     out_acc;

    logic     out_valid_reg,  out_valid_next;
    owm_out_t out_data_reg,   out_data_next;
    logic     skid_valid_reg, skid_valid_next;
    owm_out_t skid_data_reg,  skid_data_next;

    owm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_core #(
        .BYTE_GAP_TICKS (BYTE_GAP_TICKS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_acc),
        .in_word (in_data),
        .cfg     (cfg),
        .result  (step_res)
    );

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // drain the skid word into the output slot
            if (out_acc)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_acc)
            begin
                out_valid_next = 1'b1;
                out_data_next  = step_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = step_res;
            end
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with output slot empty");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.done_res |-> !out_data_reg.busy_res)
        else $error("done reported while still busy");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_acc |=> !skid_valid_reg && out_valid_reg)
        else $error("skid word not moved to output slot");

endmodule
